>>> hdl/bkhm_pkg.sv
// ----------------------------------------------------------------------------
// bkhm_pkg
// Shared types, constants and the hash round for the key hash map.
// ----------------------------------------------------------------------------
package bkhm_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int KEY_BYTES   = 16;
  localparam int KEY_W       = 128;
  localparam int LEN_W       = 5;
  localparam int VALUE_W     = 32;

  localparam logic [31:0] HASH_SEED  = 32'd3323198485;
  localparam logic [31:0] HASH_MULT  = 32'h5bd1e995;
  localparam int          HASH_SHIFT = 15;

  localparam logic [CNT_W+1:0] LOAD_LIMIT = (CNT_W + 2)'(3 * TABLE_SLOTS);

  localparam logic CMD_FIND   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_MISSING = 2'd1,
    ST_STORED  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                     used;
    logic [KEY_W-1:0]         key;
    logic signed [VALUE_W-1:0] value;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

  function automatic logic [31:0] hash_round(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = (h ^ {24'd0, b}) * HASH_MULT;
    return t ^ (t >> HASH_SHIFT);
  endfunction

  function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (LEN_W'(i) < len) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

>>> hdl/bkhm_ram.sv
// ----------------------------------------------------------------------------
// bkhm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bkhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/board_key_hash_map_top.sv
// ----------------------------------------------------------------------------
// board_key_hash_map_top
// Open-addressing key/value map with linear probing and a one-round-per-cycle
// hash unit.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                              | Handshake
//  in       | in_command, in_key_low, in_key_high, in_new_value  | valid / stall
//  out      | out_status                                         | valid / stall
//  cfg      | cfg_key_length                                     | valid / ready
//
// A command runs L hash rounds on the multiplier (L is the key length, at
// most 16), then reads and checks each probed slot through the registered
// slot RAM read port, and then presents the word.
// After reset a clearing pass marks all 1024 slots free; no word is taken
// meanwhile. A stalled result holds the block until it is taken.
// ----------------------------------------------------------------------------
module board_key_hash_map_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [63:0]                   in_key_low,
  input  logic [63:0]                   in_key_high,
  input  logic signed [31:0]            in_new_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bkhm_pkg::LEN_W-1:0]    cfg_key_length
);
  import bkhm_pkg::*;

  state_t                    state_r, state_nxt;
  logic                      cmd_r;
  logic [KEY_W-1:0]          key_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [31:0]               hash_r;
  logic [LEN_W-1:0]          byte_r;
  logic [SLOT_W-1:0]         idx_r;
  logic [SLOT_W-1:0]         steps_r;
  logic [SLOT_W-1:0]         clr_r;
  logic [CNT_W-1:0]          count_r;
  logic [LEN_W-1:0]          len_r;
  status_t                   status_r;

  logic [LEN_W-1:0]  len_eff;
  logic              in_acc;
  logic              resolve;
  logic              wr_new;
  logic              wr_upd;
  status_t           status_d;
  logic              hit;
  logic              is_free;
  logic              over_load;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  slot_t             ram_rdata;

  bkhm_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign len_eff   = (len_r > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len_r;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_DONE);
  assign out_status = status_r;

  assign is_free   = !ram_rdata.used;
  assign hit       = ram_rdata.used &&
                     (((ram_rdata.key ^ key_r) & key_mask(len_eff)) == '0);
  assign over_load = ({count_r, 2'b00} > LOAD_LIMIT);

  always_comb begin
    resolve  = 1'b0;
    wr_new   = 1'b0;
    wr_upd   = 1'b0;
    status_d = ST_MISSING;
    if (state_r == S_CHECK) begin
      resolve = is_free || hit || (steps_r == SLOT_W'(TABLE_SLOTS - 1));
      if (cmd_r == CMD_FIND) begin
        status_d = hit ? ST_FOUND : ST_MISSING;
      end else if (hit) begin
        status_d = ST_FOUND;
        wr_upd   = 1'b1;
      end else if (over_load || !is_free) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_STORED;
        wr_new   = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (byte_r == len_eff) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = resolve ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      S_CHECK: begin
        if (resolve && wr_upd) begin
          ram_we    = 1'b1;
          ram_wdata = '{used: 1'b1, key: ram_rdata.key, value: value_r};
        end else if (resolve && wr_new) begin
          ram_we    = 1'b1;
          ram_wdata = '{used: 1'b1, key: key_r, value: value_r};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      count_r <= '0;
      len_r   <= LEN_W'(KEY_BYTES);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        len_r <= cfg_key_length;
      end
      if (resolve && wr_new) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_command;
      key_r   <= {in_key_high, in_key_low};
      value_r <= in_new_value;
      hash_r  <= HASH_SEED;
      byte_r  <= '0;
    end
    if (state_r == S_HASH) begin
      if (byte_r == len_eff) begin
        idx_r   <= hash_r[SLOT_W-1:0];
        steps_r <= '0;
      end else begin
        hash_r <= hash_round(hash_r, key_r[8*byte_r[3:0] +: 8]);
        byte_r <= byte_r + 1'b1;
      end
    end
    if (state_r == S_CHECK) begin
      if (resolve) begin
        status_r <= status_d;
      end else begin
        idx_r   <= idx_r + 1'b1;
        steps_r <= steps_r + 1'b1;
      end
    end
  end

endmodule
